// ===== design/ssi_enc_pkg.sv =====
// Shared types, constants and helpers for the SSI encoder frame decoder.
// Used by every module of the decoder; no dependencies.
package ssi_enc_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int CHK_DATA_W  = 14;
  localparam int CHK_BITS_LO = 12;
  localparam logic [1:0] CHK_PASS = 2'b11;

  typedef enum logic [1:0] {
    CFG_DATA_BITS  = 2'd0,
    CFG_FRAME_MODE = 2'd1,
    CFG_OFFSET     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_CHECK = 1'b0,
    MODE_RAW   = 1'b1
  } frame_mode_e;

  typedef struct packed {
    logic [31:0] single_turn;
    logic        err;
  } dec_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [31:0] single_turn;
    logic [31:0] turns;
    logic [31:0] fails;
  } state_t;

  function automatic logic [4:0] eff_bits(logic [4:0] data_bits, logic mode);
    logic [4:0] b;
    b = (data_bits == 5'd0) ? 5'd1 : data_bits;
    if (mode == MODE_CHECK) begin
      if (b < 5'(CHK_BITS_LO)) begin
        b = 5'(CHK_BITS_LO);
      end else if (b > 5'(CHK_DATA_W)) begin
        b = 5'(CHK_DATA_W);
      end
    end
    return b;
  endfunction

endpackage

// ===== design/ssi_enc_decode.sv =====
// Frame decode: check-pair test and centering, or raw byte masking.
// Depends on ssi_enc_pkg.
module ssi_enc_decode (
  input  logic [31:0]         frame_word_i,
  input  logic [4:0]          bits_i,
  input  logic                frame_mode_i,
  input  logic [31:0]         prev_i,
  output ssi_enc_pkg::dec_t   dec_o
);

  logic [15:0] w;
  logic [1:0]  par;
  logic [31:0] mask;
  logic [31:0] half;
  logic [13:0] chk_val;
  logic [2:0]  nbytes;
  logic [5:0]  bsh;
  logic [31:0] bmask;

  assign w    = frame_word_i[15:0];
  assign mask = (32'h1 << bits_i) - 32'h1;
  assign half = 32'h1 << (bits_i - 5'd1);

  always_comb begin
    par = w[15:14];
    for (int i = 0; i < 7; i++) begin
      par = par ^ w[2*i +: 2];
    end
  end

  assign chk_val = w[13:0] >> (5'(ssi_enc_pkg::CHK_DATA_W) - bits_i);

  always_comb begin
    nbytes = 3'((bits_i - 5'd1) >> 3) + 3'd1;
    if (nbytes > 3'(ssi_enc_pkg::FRAME_BYTES)) begin
      nbytes = 3'(ssi_enc_pkg::FRAME_BYTES);
    end
    bsh   = {nbytes, 3'b000};
    bmask = (nbytes >= 3'd4) ? 32'hFFFF_FFFF : ((32'h1 << bsh) - 32'h1);
  end

  always_comb begin
    if (frame_mode_i == ssi_enc_pkg::MODE_CHECK) begin
      if (par == ssi_enc_pkg::CHK_PASS) begin
        dec_o.single_turn = ({18'b0, chk_val} & mask) - half;
        dec_o.err         = 1'b0;
      end else begin
        dec_o.single_turn = prev_i;
        dec_o.err         = 1'b1;
      end
    end else begin
      dec_o.single_turn = frame_word_i & bmask & mask;
      dec_o.err         = 1'b0;
    end
  end

endmodule

// ===== design/ssi_enc_track.sv =====
// Turn tracking stage: single-turn, turn and fail counters, one beat per cycle while load_i is high.
// Depends on ssi_enc_pkg.
module ssi_enc_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  drain_i,
  input  logic [4:0]            bits_i,
  input  ssi_enc_pkg::dec_t     dec_i,
  output ssi_enc_pkg::state_t   state_o
);

  logic        valid_q, valid_d;
  logic        err_q;
  logic [31:0] st_q, tc_q, fc_q;
  logic [31:0] tc_d, fc_d;
  logic [32:0] diff, half33, nhalf33;

  assign half33  = {1'b0, 32'h1 << (bits_i - 5'd1)};
  assign nhalf33 = 33'd0 - half33;
  assign diff    = {dec_i.single_turn[31], dec_i.single_turn} - {st_q[31], st_q};

  always_comb begin
    tc_d = tc_q;
    if ($signed(diff) > $signed(half33)) begin
      tc_d = tc_q - 32'd1;
    end else if ($signed(diff) < $signed(nhalf33)) begin
      tc_d = tc_q + 32'd1;
    end
    fc_d    = dec_i.err ? fc_q + 32'd1 : fc_q;
    valid_d = load_i ? 1'b1 : (drain_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      err_q   <= 1'b0;
      st_q    <= '0;
      tc_q    <= '0;
      fc_q    <= '0;
    end else begin
      valid_q <= valid_d;
      if (load_i) begin
        err_q <= dec_i.err;
        st_q  <= dec_i.single_turn;
        tc_q  <= tc_d;
        fc_q  <= fc_d;
      end
    end
  end

  assign state_o.valid       = valid_q;
  assign state_o.err         = err_q;
  assign state_o.single_turn = st_q;
  assign state_o.turns       = tc_q;
  assign state_o.fails       = fc_q;

endmodule

// ===== design/ssi_encoder_frame_decode.sv =====
// SSI encoder frame decoder top level: input register, decode and turn tracking,
// output register with the multi-turn position.
// Beats pass the input, tracker and output registers in order, one beat per
// cycle while out_stall_i is low; the turn tracker updates its state once per
// beat. Reset clears the pipeline valids and the counters and resets the
// configuration. Depends on ssi_enc_pkg, ssi_enc_decode and ssi_enc_track.
module ssi_encoder_frame_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] frame_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] turn_position_o,
  output logic signed [31:0] turns_o,
  output logic        frame_error_o,
  output logic [31:0] error_count_o
);

  logic [4:0]  data_bits_q;
  logic        frame_mode_q;
  logic [31:0] offset_q;
  logic [4:0]  bits;

  logic        in_v_q;
  logic [31:0] word_q;
  logic        out_v_q;
  logic [31:0] pos_q, tp_q, turns_q, errc_q;
  logic        ferr_q;

  logic adv1, adv2, adv3, take1, take2;

  ssi_enc_pkg::dec_t   dec;
  ssi_enc_pkg::state_t st;

  assign bits = ssi_enc_pkg::eff_bits(data_bits_q, frame_mode_q);

  assign adv3  = st.valid && (!out_v_q || !out_stall_i);
  assign take2 = !st.valid || adv3;
  assign adv2  = in_v_q && take2;
  assign take1 = !in_v_q || adv2;
  assign adv1  = in_valid_i && take1;
  assign in_stall_o = !take1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q  <= 5'd14;
      frame_mode_q <= ssi_enc_pkg::MODE_CHECK;
      offset_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (ssi_enc_pkg::cfg_idx_e'(cfg_index_i))
        ssi_enc_pkg::CFG_DATA_BITS:  data_bits_q  <= cfg_wdata_i[4:0];
        ssi_enc_pkg::CFG_FRAME_MODE: frame_mode_q <= cfg_wdata_i[0];
        ssi_enc_pkg::CFG_OFFSET:     offset_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= adv1 ? 1'b1 : (adv2 ? 1'b0 : in_v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      word_q <= frame_word_i;
    end
  end

  ssi_enc_decode u_decode (
    .frame_word_i (word_q),
    .bits_i       (bits),
    .frame_mode_i (frame_mode_q),
    .prev_i       (st.single_turn),
    .dec_o        (dec)
  );

  ssi_enc_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv2),
    .drain_i (adv3),
    .bits_i  (bits),
    .dec_i   (dec),
    .state_o (st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= adv3 ? 1'b1 : ((out_v_q && !out_stall_i) ? 1'b0 : out_v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      pos_q   <= st.single_turn + (st.turns << bits) - offset_q;
      tp_q    <= st.single_turn;
      turns_q <= st.turns;
      ferr_q  <= st.err;
      errc_q  <= st.fails;
    end
  end

  assign out_valid_o     = out_v_q;
  assign position_o      = pos_q;
  assign turn_position_o = tp_q;
  assign turns_o         = turns_q;
  assign frame_error_o   = ferr_q;
  assign error_count_o   = errc_q;

endmodule

// ===== design/ssi_enc_checker.sv =====
// Port-level checker for the SSI encoder frame decoder, bound to the top level.
// Depends on ssi_encoder_frame_decode ports only.
module ssi_enc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] position_o,
  input logic [31:0] turn_position_o,
  input logic [31:0] turns_o,
  input logic        frame_error_o,
  input logic [31:0] error_count_o
);

  logic        out_beat;
  logic [31:0] prev_tp_q, prev_turns_q, prev_errc_q;
  logic [31:0] turn_step;

  assign out_beat  = out_valid_o && !out_stall_i;
  assign turn_step = turns_o - prev_turns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tp_q    <= '0;
      prev_turns_q <= '0;
      prev_errc_q  <= '0;
    end else if (out_beat) begin
      prev_tp_q    <= turn_position_o;
      prev_turns_q <= turns_o;
      prev_errc_q  <= error_count_o;
    end
  end

  a_errc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> error_count_o == prev_errc_q + {31'b0, frame_error_o})
    else $error("error count does not follow frame errors");

  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && frame_error_o) |->
      (turn_position_o == prev_tp_q && turns_o == prev_turns_q))
    else $error("failed frame moved the position state");

  a_turn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (turn_step == 32'd0 || turn_step == 32'd1 || turn_step == 32'hFFFF_FFFF))
    else $error("turn counter moved by more than one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(position_o)))
    else $error("stalled result beat changed");

endmodule

bind ssi_encoder_frame_decode ssi_enc_checker u_ssi_enc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .position_o      (position_o),
  .turn_position_o (turn_position_o),
  .turns_o         (turns_o),
  .frame_error_o   (frame_error_o),
  .error_count_o   (error_count_o)
);
